// ===== hdl/macpu_pkg.sv =====
// shared types, opcodes and micro-step codes of the accumulator cpu
package macpu_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned STEP_W = 3;
    localparam int unsigned RAM_DEPTH = 16;

    localparam logic [STEP_W-1:0] STEP_ADDR  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FETCH = 3'd1;
    localparam logic [STEP_W-1:0] STEP_EXEC  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MEM   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ALU   = 3'd4;

    typedef enum logic [3:0] {
        OP_NOP = 4'h0,
        OP_LDA = 4'h1,
        OP_ADD = 4'h2,
        OP_SUB = 4'h3,
        OP_STA = 4'h4,
        OP_LDI = 4'h5,
        OP_JMP = 4'h6,
        OP_JC  = 4'h7,
        OP_JZ  = 4'h8,
        OP_OUT = 4'hE,
        OP_HLT = 4'hF
    } t_opcode;

    typedef enum logic [1:0] {
        ALU_NONE = 2'd0,
        ALU_ADD  = 2'd1,
        ALU_SUB  = 2'd2
    } t_alu_mode;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0] mem_data;
    } t_in_item;

    typedef struct packed {
        logic              halted;
        logic              out_valid;
        logic [DATA_W-1:0] out_value;
        logic [DATA_W-1:0] pc_value;
        logic [DATA_W-1:0] acc_value;
        logic              carry_flag;
        logic              zero_flag;
        logic [STEP_W-1:0] step_index;
    } t_out_item;

    // control group from the pipeline to the core
    typedef struct packed {
        logic     fire;
        t_in_item item;
    } t_core_req;

endpackage

// ===== hdl/macpu_if.sv =====
// valid/ready channel interfaces for input items and result items
interface macpu_in_if;
    logic                 valid;
    logic                 ready;
    macpu_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface macpu_out_if;
    logic                 valid;
    logic                 ready;
    macpu_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/microcoded_accumulator_cpu.sv =====
// top level: input register, cpu core and result register
// an item's result reaches the result port through the input register and then the result
// register, which holds the state after the micro-step
// one item per cycle while the result port does not stall; the micro-step is combinational
// reset: synchronous active-low; clears all cpu registers and the 16-byte ram
// at once, both pipeline stages come up empty
module microcoded_accumulator_cpu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    macpu_in_if.sink    i_in,
    macpu_out_if.source o_out
);

    logic                 r_in_valid;
    macpu_pkg::t_in_item  r_in_item;
    logic                 r_out_valid;
    macpu_pkg::t_out_item r_out_item;
    logic                 step_fire;
    macpu_pkg::t_core_req core_req;
    macpu_pkg::t_out_item core_res;

    // item moves from the input register into the result register
    assign step_fire  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || step_fire;

    assign core_req.fire = step_fire;
    assign core_req.item = r_in_item;

    macpu_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (step_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_item <= i_in.data;
        end
        if (step_fire) begin
            r_out_item <= core_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

endmodule

// ===== hdl/macpu_core.sv =====
// architectural state, ram and one micro-step of the accumulator cpu
module macpu_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  macpu_pkg::t_core_req  i_req,
    output macpu_pkg::t_out_item  o_res
);

    localparam int unsigned DW = macpu_pkg::DATA_W;
    localparam int unsigned AW = macpu_pkg::ADDR_W;
    localparam int unsigned SW = macpu_pkg::STEP_W;

    logic [DW-1:0] r_pc, n_pc;
    logic [DW-1:0] r_ir, n_ir;
    logic [AW-1:0] r_mar, n_mar;
    logic [DW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_b, n_b;
    logic [DW-1:0] r_out, n_out;
    logic          r_c, n_c;
    logic          r_z, n_z;
    logic          r_halt, n_halt;
    logic [SW-1:0] r_step, n_step;
    macpu_pkg::t_alu_mode r_alu, n_alu;
    logic [DW-1:0] r_ram [macpu_pkg::RAM_DEPTH];

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [DW-1:0] ram_rdata;
    logic          outv;
    logic [DW:0]   alu_res;

    macpu_pkg::t_opcode op;
    logic [AW-1:0]      arg;

    assign op        = macpu_pkg::t_opcode'(r_ir[DW-1:AW]);
    assign arg       = r_ir[AW-1:0];
    assign ram_rdata = r_ram[r_mar];

    // 9-bit add/subtract: top bit is carry or borrow
    always_comb begin
        if (r_alu == macpu_pkg::ALU_SUB) begin
            alu_res = {1'b0, r_acc} - {1'b0, r_b};
        end else begin
            alu_res = {1'b0, r_acc} + {1'b0, r_b};
        end
    end

    always_comb begin
        n_pc      = r_pc;
        n_ir      = r_ir;
        n_mar     = r_mar;
        n_acc     = r_acc;
        n_b       = r_b;
        n_out     = r_out;
        n_c       = r_c;
        n_z       = r_z;
        n_halt    = r_halt;
        n_step    = r_step;
        n_alu     = r_alu;
        ram_we    = 1'b0;
        ram_waddr = i_req.item.mem_addr;
        ram_wdata = i_req.item.mem_data;
        outv      = 1'b0;
        if (i_req.item.func == macpu_pkg::FUNC_WRITE) begin
            ram_we = 1'b1;
        end else if (!r_halt) begin
            unique case (r_step)
                macpu_pkg::STEP_ADDR: begin
                    n_mar  = r_pc[AW-1:0];
                    n_step = macpu_pkg::STEP_FETCH;
                end
                macpu_pkg::STEP_FETCH: begin
                    n_ir   = ram_rdata;
                    n_pc   = r_pc + DW'(1);
                    n_step = macpu_pkg::STEP_EXEC;
                end
                default: begin
                    n_step = macpu_pkg::STEP_ADDR;
                    unique case (op) inside
                        macpu_pkg::OP_LDA, macpu_pkg::OP_ADD,
                        macpu_pkg::OP_SUB, macpu_pkg::OP_STA: begin
                            if (r_step == macpu_pkg::STEP_EXEC) begin
                                n_mar  = arg;
                                n_step = macpu_pkg::STEP_MEM;
                            end else if (r_step == macpu_pkg::STEP_MEM) begin
                                if (op == macpu_pkg::OP_LDA) begin
                                    n_acc = ram_rdata;
                                end else if (op == macpu_pkg::OP_STA) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_mar;
                                    ram_wdata = r_acc;
                                end else begin
                                    n_b    = ram_rdata;
                                    n_alu  = (op == macpu_pkg::OP_ADD) ?
                                             macpu_pkg::ALU_ADD : macpu_pkg::ALU_SUB;
                                    n_step = macpu_pkg::STEP_ALU;
                                end
                            end else if (r_step == macpu_pkg::STEP_ALU &&
                                         (op == macpu_pkg::OP_ADD ||
                                          op == macpu_pkg::OP_SUB)) begin
                                n_acc = alu_res[DW-1:0];
                                n_c   = alu_res[DW];
                                n_z   = (alu_res[DW-1:0] == '0);
                            end
                        end
                        macpu_pkg::OP_LDI: begin
                            if (r_step == macpu_pkg::STEP_EXEC) begin
                                n_acc = {{(DW-AW){1'b0}}, arg};
                            end
                        end
                        macpu_pkg::OP_JMP: begin
                            if (r_step == macpu_pkg::STEP_EXEC) begin
                                n_pc = {{(DW-AW){1'b0}}, arg};
                            end
                        end
                        macpu_pkg::OP_JC, macpu_pkg::OP_JZ: begin
                            if (r_step == macpu_pkg::STEP_EXEC) begin
                                if ((op == macpu_pkg::OP_JC) ? r_c : r_z) begin
                                    n_pc = {{(DW-AW){1'b0}}, arg};
                                end
                                n_step = macpu_pkg::STEP_MEM;
                            end
                        end
                        macpu_pkg::OP_OUT: begin
                            if (r_step == macpu_pkg::STEP_EXEC) begin
                                n_out = r_acc;
                                outv  = 1'b1;
                            end
                        end
                        macpu_pkg::OP_NOP: begin
                        end
                        // HLT and the unused opcodes stop the machine
                        default: begin
                            if (r_step == macpu_pkg::STEP_EXEC) begin
                                n_halt = 1'b1;
                            end
                        end
                    endcase
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_ir   <= '0;
            r_mar  <= '0;
            r_acc  <= '0;
            r_b    <= '0;
            r_out  <= '0;
            r_c    <= 1'b0;
            r_z    <= 1'b0;
            r_halt <= 1'b0;
            r_step <= macpu_pkg::STEP_ADDR;
            r_alu  <= macpu_pkg::ALU_NONE;
            r_ram  <= '{default: '0};
        end else if (i_req.fire) begin
            r_pc   <= n_pc;
            r_ir   <= n_ir;
            r_mar  <= n_mar;
            r_acc  <= n_acc;
            r_b    <= n_b;
            r_out  <= n_out;
            r_c    <= n_c;
            r_z    <= n_z;
            r_halt <= n_halt;
            r_step <= n_step;
            r_alu  <= n_alu;
            if (ram_we) begin
                r_ram[ram_waddr] <= ram_wdata;
            end
        end
    end

    always_comb begin
        o_res.halted     = n_halt;
        o_res.out_valid  = outv;
        o_res.out_value  = n_out;
        o_res.pc_value   = n_pc;
        o_res.acc_value  = n_acc;
        o_res.carry_flag = n_c;
        o_res.zero_flag  = n_z;
        o_res.step_index = n_step;
    end

    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt bit cleared without reset");

    a_halted_tick_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.fire && r_halt && i_req.item.func == macpu_pkg::FUNC_TICK)
        |=> ($stable(r_pc) && $stable(r_acc) && $stable(r_step) && $stable(r_out)))
        else $error("state changed on a tick while halted");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= macpu_pkg::STEP_ALU)
        else $error("micro-step out of range");

    a_write_keeps_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.fire && i_req.item.func == macpu_pkg::FUNC_WRITE) |=> $stable(r_step))
        else $error("ram write advanced the micro-step");

    a_out_ends_instr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.fire && outv) |=> (r_step == macpu_pkg::STEP_ADDR))
        else $error("output load did not end the instruction");

endmodule

// ===== tb/tb.sv =====
// testbench for the accumulator cpu: random programs checked against a micro-step predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_PROGRAMS   = 6;

    // opcodes that halt besides OP_HLT
    localparam logic [3:0] OP_HALT_LO = 4'h9;
    localparam logic [3:0] OP_HALT_HI = 4'hD;

    logic clk;
    logic rst_n;

    macpu_in_if  in_ch ();
    macpu_out_if out_ch ();

    microcoded_accumulator_cpu uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // predicted cpu state
    logic [7:0]  cpu_pc;
    logic [7:0]  cpu_ir;
    logic [3:0]  cpu_mar;
    logic [7:0]  cpu_acc;
    logic [7:0]  cpu_b;
    logic [7:0]  cpu_out;
    logic        cpu_cy;
    logic        cpu_z;
    macpu_pkg::t_alu_mode cpu_alu;
    logic [2:0]  cpu_step;
    logic        cpu_halt;
    logic [7:0]  cpu_mem [macpu_pkg::RAM_DEPTH];

    macpu_pkg::t_out_item expected_state_q [$];

    int  err_cnt;
    int  items_sent;
    int  states_checked;
    int  out_loads;
    int  taken_branches;
    int  idle_cycles;
    bit  in_idle_on;
    bit  out_idle_on;
    bit  long_hold_req;
    bit  pc_wrapped;
    logic [3:0] halt_op_used;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    task automatic reset_cpu_model();
        cpu_pc   = '0;
        cpu_ir   = '0;
        cpu_mar  = '0;
        cpu_acc  = '0;
        cpu_b    = '0;
        cpu_out  = '0;
        cpu_cy   = 1'b0;
        cpu_z    = 1'b0;
        cpu_alu  = macpu_pkg::ALU_NONE;
        cpu_step = macpu_pkg::STEP_ADDR;
        cpu_halt = 1'b0;
        foreach (cpu_mem[i]) cpu_mem[i] = '0;
    endtask

    // one item through the predictor, returns the state the block should report
    task automatic step_cpu_model(input macpu_pkg::t_in_item it,
                                  output macpu_pkg::t_out_item res);
        logic [3:0] opc;
        logic [3:0] arg;
        logic [2:0] nxt;
        logic [8:0] sum;
        logic       flag;
        logic       loaded;
        opc    = cpu_ir[7:4];
        arg    = cpu_ir[3:0];
        loaded = 1'b0;
        if (it.func == macpu_pkg::FUNC_WRITE) begin
            cpu_mem[it.mem_addr] = it.mem_data;
        end else if (!cpu_halt) begin
            nxt = cpu_step + 3'd1;
            if (cpu_step == macpu_pkg::STEP_ADDR) begin
                cpu_mar = cpu_pc[3:0];
            end else if (cpu_step == macpu_pkg::STEP_FETCH) begin
                cpu_ir = cpu_mem[cpu_mar];
                cpu_pc = cpu_pc + 8'd1;
            end else begin
                nxt = macpu_pkg::STEP_ADDR;
                case (opc) inside
                    macpu_pkg::OP_LDA, macpu_pkg::OP_ADD,
                    macpu_pkg::OP_SUB, macpu_pkg::OP_STA: begin
                        if (cpu_step == macpu_pkg::STEP_EXEC) begin
                            cpu_mar = arg;
                            nxt = macpu_pkg::STEP_MEM;
                        end else if (cpu_step == macpu_pkg::STEP_MEM) begin
                            if (opc == macpu_pkg::OP_LDA) begin
                                cpu_acc = cpu_mem[cpu_mar];
                            end else if (opc == macpu_pkg::OP_STA) begin
                                cpu_mem[cpu_mar] = cpu_acc;
                            end else begin
                                cpu_b   = cpu_mem[cpu_mar];
                                cpu_alu = (opc == macpu_pkg::OP_ADD) ?
                                          macpu_pkg::ALU_ADD : macpu_pkg::ALU_SUB;
                                nxt     = macpu_pkg::STEP_ALU;
                            end
                        end else if (cpu_step == macpu_pkg::STEP_ALU &&
                                     (opc == macpu_pkg::OP_ADD ||
                                      opc == macpu_pkg::OP_SUB)) begin
                            if (cpu_alu == macpu_pkg::ALU_SUB) begin
                                sum    = {1'b0, cpu_acc} - {1'b0, cpu_b};
                                cpu_cy = (cpu_acc < cpu_b);
                            end else begin
                                sum    = {1'b0, cpu_acc} + {1'b0, cpu_b};
                                cpu_cy = sum[8];
                            end
                            cpu_z   = (sum[7:0] == 8'd0);
                            cpu_acc = sum[7:0];
                        end
                    end
                    macpu_pkg::OP_LDI: begin
                        if (cpu_step == macpu_pkg::STEP_EXEC) cpu_acc = {4'd0, arg};
                    end
                    macpu_pkg::OP_JMP: begin
                        if (cpu_step == macpu_pkg::STEP_EXEC) cpu_pc = {4'd0, arg};
                    end
                    macpu_pkg::OP_JC, macpu_pkg::OP_JZ: begin
                        if (cpu_step == macpu_pkg::STEP_EXEC) begin
                            flag = (opc == macpu_pkg::OP_JC) ? cpu_cy : cpu_z;
                            if (flag) begin
                                cpu_pc = {4'd0, arg};
                                taken_branches++;
                            end
                            nxt = macpu_pkg::STEP_MEM;
                        end
                    end
                    macpu_pkg::OP_OUT: begin
                        if (cpu_step == macpu_pkg::STEP_EXEC) begin
                            cpu_out = cpu_acc;
                            loaded  = 1'b1;
                            out_loads++;
                        end
                    end
                    macpu_pkg::OP_NOP: ;
                    default: begin
                        if (cpu_step == macpu_pkg::STEP_EXEC) cpu_halt = 1'b1;
                    end
                endcase
            end
            cpu_step = nxt;
        end
        res.halted     = cpu_halt;
        res.out_valid  = loaded;
        res.out_value  = cpu_out;
        res.pc_value   = cpu_pc;
        res.acc_value  = cpu_acc;
        res.carry_flag = cpu_cy;
        res.zero_flag  = cpu_z;
        res.step_index = cpu_step;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic macpu_pkg::t_in_item make_tick();
        macpu_pkg::t_in_item it;
        it.func     = macpu_pkg::FUNC_TICK;
        it.mem_addr = 4'($urandom_range(0, macpu_pkg::RAM_DEPTH - 1));
        it.mem_data = 8'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic macpu_pkg::t_in_item make_write(logic [3:0] addr, logic [7:0] data);
        macpu_pkg::t_in_item it;
        it.func     = macpu_pkg::FUNC_WRITE;
        it.mem_addr = addr;
        it.mem_data = data;
        return it;
    endfunction

    // instructions a running program may fetch without halting the cpu for good
    function automatic bit fetch_allowed(logic [7:0] instr, bit no_jumps);
        case (instr[7:4]) inside
            macpu_pkg::OP_NOP, macpu_pkg::OP_LDA, macpu_pkg::OP_ADD, macpu_pkg::OP_SUB,
            macpu_pkg::OP_STA, macpu_pkg::OP_LDI, macpu_pkg::OP_OUT: return 1'b1;
            macpu_pkg::OP_JMP, macpu_pkg::OP_JC, macpu_pkg::OP_JZ: return !no_jumps;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] rand_instr(bit no_jumps);
        macpu_pkg::t_opcode op;
        case ($urandom_range(0, no_jumps ? 6 : 9))
            0: op = macpu_pkg::OP_NOP;
            1: op = macpu_pkg::OP_LDA;
            2: op = macpu_pkg::OP_ADD;
            3: op = macpu_pkg::OP_SUB;
            4: op = macpu_pkg::OP_STA;
            5: op = macpu_pkg::OP_LDI;
            6: op = macpu_pkg::OP_OUT;
            7: op = macpu_pkg::OP_JMP;
            8: op = macpu_pkg::OP_JC;
            default: op = macpu_pkg::OP_JZ;
        endcase
        return {op, 4'($urandom_range(0, 15))};
    endfunction

    // sends one item, waits for its transfer, then records the predicted state
    task automatic send_item(input macpu_pkg::t_in_item it);
        int                   g;
        macpu_pkg::t_out_item res;
        g = in_idle_on ? pick_gap() : 0;
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge clk); while (!in_ch.ready);
        step_cpu_model(it, res);
        expected_state_q.push_back(res);
        items_sent++;
    endtask

    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (expected_state_q.size() != 0) @(posedge clk);
    endtask

    // ticks with some stray ram writes; a fetch that would halt is patched first
    task automatic run_ticks(input int n, input bit no_jumps);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 8)
                send_item(make_write(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
            if (cpu_step == macpu_pkg::STEP_FETCH &&
                !fetch_allowed(cpu_mem[cpu_mar], no_jumps))
                send_item(make_write(cpu_mar, rand_instr(no_jumps)));
            send_item(make_tick());
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] a);
        if (e !== a) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("tb: result %0d field %s expected %0h got %0h",
                         states_checked, name, e, a);
        end
    endtask

    task automatic check_result(input macpu_pkg::t_out_item got);
        macpu_pkg::t_out_item e;
        if (expected_state_q.size() == 0) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("tb: unexpected result %p", got);
            return;
        end
        e = expected_state_q.pop_front();
        check_field("halted", 8'(e.halted), 8'(got.halted));
        check_field("out_valid", 8'(e.out_valid), 8'(got.out_valid));
        check_field("out_value", e.out_value, got.out_value);
        check_field("pc_value", e.pc_value, got.pc_value);
        check_field("acc_value", e.acc_value, got.acc_value);
        check_field("carry_flag", 8'(e.carry_flag), 8'(got.carry_flag));
        check_field("zero_flag", 8'(e.zero_flag), 8'(got.zero_flag));
        check_field("step_index", 8'(e.step_index), 8'(got.step_index));
        states_checked++;
    endtask

    // result side: random back-pressure plus a long hold on request
    initial begin
        int hold;
        hold = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) check_result(out_ch.data);
            if (long_hold_req) begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else if (!out_idle_on || $urandom_range(0, 99) < 70) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b0;
                hold = pick_gap();
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: no transfer for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_state_q.size());
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // lda/add with carry and zero, taken jc, sub with borrow, out; field extremes
    task automatic test_directed_program();
        send_item(make_write(4'd15, 8'hFF));
        send_item(make_write(4'd14, 8'h01));
        send_item(make_write(4'd0, {macpu_pkg::OP_LDA, 4'd15}));
        send_item(make_write(4'd1, {macpu_pkg::OP_ADD, 4'd14}));
        send_item(make_write(4'd2, {macpu_pkg::OP_JC, 4'd4}));
        send_item(make_write(4'd3, 8'h00));
        send_item(make_write(4'd4, {macpu_pkg::OP_SUB, 4'd14}));
        send_item(make_write(4'd5, {macpu_pkg::OP_OUT, 4'd0}));
        for (int i = 0; i < 21; i++) send_item(make_tick());
    endtask

    task automatic test_random_programs();
        logic [7:0] b;
        for (int p = 0; p < NUM_PROGRAMS; p++) begin
            in_idle_on  = (p % 3 != 0);
            out_idle_on = (p % 3 != 1);
            for (int a = 0; a < macpu_pkg::RAM_DEPTH; a++) begin
                b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : rand_instr(1'b0);
                if (!fetch_allowed(b, 1'b0)) b = rand_instr(1'b0);
                send_item(make_write(a[3:0], b));
            end
            run_ticks($urandom_range(60, 110), 1'b0);
        end
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
    endtask

    // receiver stops for a long while, sender keeps pushing back to back
    task automatic test_output_stall();
        in_idle_on    = 1'b0;
        long_hold_req = 1'b1;
        run_ticks(40, 1'b0);
        in_idle_on    = 1'b1;
    endtask

    task automatic test_input_pause();
        run_ticks(20, 1'b0);
        wait_all_results();
        run_ticks(20, 1'b0);
    endtask

    // straight-line code until the 8-bit program counter rolls over
    task automatic test_pc_wrap();
        logic [7:0] prev;
        int         guard;
        for (int a = 0; a < macpu_pkg::RAM_DEPTH; a++)
            send_item(make_write(a[3:0], rand_instr(1'b1)));
        guard = 0;
        while (!pc_wrapped && guard < 3000) begin
            prev = cpu_pc;
            run_ticks(1, 1'b1);
            if (prev == 8'hFF && cpu_pc == 8'h00) pc_wrapped = 1'b1;
            guard++;
        end
        run_ticks(20, 1'b0);
    endtask

    // one halting opcode, then ticks and ram writes while halted
    task automatic test_halt();
        logic [3:0] op;
        op = OP_HALT_LO + 4'($urandom_range(0, 5));
        if (op > OP_HALT_HI) op = macpu_pkg::OP_HLT;
        halt_op_used = op;
        for (int a = 0; a < macpu_pkg::RAM_DEPTH; a++)
            send_item(make_write(a[3:0], {op, 4'($urandom_range(0, 15))}));
        while (!cpu_halt) send_item(make_tick());
        for (int i = 0; i < 6; i++) send_item(make_tick());
        send_item(make_write(4'd0, 8'h00));
        send_item(make_write(4'd15, 8'hFF));
        send_item(make_write(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255))));
        for (int i = 0; i < 3; i++) send_item(make_tick());
    endtask

    initial begin
        err_cnt        = 0;
        items_sent     = 0;
        states_checked = 0;
        out_loads      = 0;
        taken_branches = 0;
        in_idle_on     = 1'b1;
        out_idle_on    = 1'b1;
        long_hold_req  = 1'b0;
        pc_wrapped     = 1'b0;
        halt_op_used   = macpu_pkg::OP_HLT;
        reset_cpu_model();
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_program();
        test_random_programs();
        test_output_stall();
        test_input_pause();
        test_pc_wrap();
        test_halt();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d items, %0d states checked, %0d output loads, %0d taken branches",
                 items_sent, states_checked, out_loads, taken_branches);
        $display("tb: pc rollover %0s, halted by opcode %h, %0d mismatches",
                 pc_wrapped ? "seen" : "not seen", halt_op_used, err_cnt);
        if (err_cnt == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== microcoded_accumulator_cpu.f =====
hdl/macpu_pkg.sv
hdl/macpu_if.sv
hdl/macpu_core.sv
hdl/microcoded_accumulator_cpu.sv
tb/tb.sv
